>>> sv/swir_pkg.sv
// shared types and constants of the synapse weight index resolver
package swir_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS;

    localparam logic [2:0] REG_NEURON_COUNT    = 3'd0;
    localparam logic [2:0] REG_POST_ROW_LAYOUT = 3'd1;
    localparam logic [2:0] REG_COLUMN_COUNT    = 3'd2;
    localparam logic [2:0] REG_WINDOW_BASE     = 3'd3;
    localparam logic [2:0] REG_CORE_NUMBER     = 3'd4;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] num;
        logic [15:0]           rem;
        logic [15:0]           pre_sel;
        logic [15:0]           post;
        logic                  ok;
        logic                  need_div;
    } div_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] req_pre_index;
        logic [15:0] req_post_index;
        logic [31:0] weight_key;
    } result_t;

endpackage

>>> sv/swir_front.sv
// range checks, window test and remap dividend, two pipeline stages
module swir_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_pre,
    input  logic [31:0]         in_post,
    input  logic                in_remap,
    input  logic [15:0]         neuron_count,
    input  logic                post_row_layout,
    input  logic [15:0]         column_count,
    input  logic [31:0]         window_base,
    input  logic [15:0]         core_number,
    output logic                out_valid,
    input  logic                out_ready,
    output swir_pkg::div_item_t out_item
);
    import swir_pkg::*;

    typedef struct packed {
        logic [31:0] pre;
        logic [15:0] post;
        logic [15:0] local_idx;
        logic [31:0] prod;
        logic        post_ok;
        logic        pr_ok;
        logic        local_hit;
        logic        remap;
    } front_t;

    logic      v1_reg;
    front_t    s1_reg;
    front_t    s1_next;
    logic      v2_reg;
    div_item_t s2_reg;
    div_item_t s2_next;
    logic      en1;
    logic      en2;
    logic [31:0] offset;
    logic [33:0] sum;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: compares and core origin product
    always_comb
    begin
        offset              = in_pre - window_base;
        s1_next.pre         = in_pre;
        s1_next.post        = in_post[15:0];
        s1_next.local_idx   = offset[15:0];
        s1_next.prod        = {16'd0, core_number} * {16'd0, neuron_count};
        s1_next.post_ok     = in_post < {16'd0, neuron_count};
        s1_next.pr_ok       = in_pre < {16'd0, column_count};
        s1_next.local_hit   = (in_pre >= window_base) && (offset < {16'd0, neuron_count});
        s1_next.remap       = in_remap;
    end

    // stage 2: dividend pre - (base - core*count), wrapped to 64 bits
    always_comb
    begin
        sum              = {2'b00, s1_reg.pre} - {2'b00, window_base} + {2'b00, s1_reg.prod};
        s2_next.num      = {{(DIVIDEND_W-34){sum[33]}}, sum};
        s2_next.rem      = 16'd0;
        s2_next.pre_sel  = post_row_layout ? s1_reg.pre[15:0] : s1_reg.local_idx;
        s2_next.post     = s1_reg.post;
        s2_next.ok       = s1_reg.post_ok &&
                           (post_row_layout ? s1_reg.pr_ok : (s1_reg.local_hit || s1_reg.remap));
        s2_next.need_div = !post_row_layout && !s1_reg.local_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = s2_reg;

endmodule

>>> sv/swir_rem_stage.sv
// one stage of the pipelined remainder unit, DIV_BITS (4) dividend bits per stage
module swir_rem_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  swir_pkg::div_item_t in_item,
    input  logic [15:0]         divisor,
    output logic                out_valid,
    input  logic                out_ready,
    output swir_pkg::div_item_t out_item
);
    import swir_pkg::*;

    logic      v_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic      en;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    // restoring remainder steps, msb first
    always_comb
    begin
        logic [15:0]           r;
        logic [DIVIDEND_W-1:0] n;
        logic [16:0]           t;
        r = in_item.rem;
        n = in_item.num;
        t = 17'd0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {r, n[DIVIDEND_W-1]};
            n = {n[DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[15:0];
        end
        item_next     = in_item;
        item_next.num = n;
        item_next.rem = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = item_reg;

endmodule

>>> sv/swir_key.sv
// weight key multiply and add, last stage is the output register
module swir_key #(
    parameter logic [15:0] IDX_MASK = 16'hFFFF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  swir_pkg::div_item_t in_item,
    input  logic [15:0]         neuron_count,
    input  logic                post_row_layout,
    input  logic [15:0]         column_count,
    output logic                out_valid,
    input  logic                out_ready,
    output swir_pkg::result_t   out_res
);
    import swir_pkg::*;

    typedef struct packed {
        logic [31:0] prod;
        logic [15:0] addend;
        logic [15:0] pre;
        logic [15:0] post;
        logic        ok;
    } mul_t;

    logic    va_reg;
    mul_t    a_reg;
    mul_t    a_next;
    logic    vb_reg;
    result_t b_reg;
    result_t b_next;
    logic    ena;
    logic    enb;
    logic [15:0] pre_idx;

    assign enb      = !vb_reg || out_ready;
    assign ena      = !va_reg || enb;
    assign in_ready = ena;

    always_comb
    begin
        pre_idx = in_item.need_div ? in_item.rem : in_item.pre_sel;
        a_next.pre  = pre_idx;
        a_next.post = in_item.post;
        a_next.ok   = in_item.ok;
        if (post_row_layout)
        begin
            a_next.prod   = {16'd0, in_item.post} * {16'd0, column_count};
            a_next.addend = pre_idx;
        end
        else
        begin
            a_next.prod   = {16'd0, pre_idx} * {16'd0, neuron_count};
            a_next.addend = in_item.post;
        end
    end

    always_comb
    begin
        b_next.valid_res      = a_reg.ok;
        b_next.req_pre_index  = a_reg.ok ? (a_reg.pre & IDX_MASK) : 16'd0;
        b_next.req_post_index = a_reg.ok ? (a_reg.post & IDX_MASK) : 16'd0;
        b_next.weight_key     = a_reg.ok ? (a_reg.prod + {16'd0, a_reg.addend}) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ena)
            begin
                va_reg <= in_valid;
            end
            if (enb)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ena && in_valid)
        begin
            a_reg <= a_next;
        end
        if (enb && va_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_res   = b_reg;

endmodule

>>> sv/synapse_weight_index_resolver.sv
// top level of the synapse weight index resolver
//
//   channel   direction  transfer fields
//   s_*       in         tdata: pre_global_id[31:0], post_index[63:32]; tuser: remap_allowed
//   m_*       out        tdata: req_pre_index[15:0], req_post_index[31:16], weight_key[63:32];
//                        tuser: valid_res
//   cfg_*     in         cfg_index selects register, cfg_data written when cfg_we is high
//
// one transfer per cycle sustained while m_tready is high; the pipeline from s_* to m_* is
// two front stages, 16 remainder stages at 4 dividend bits each, multiply and add
// every stage has its own valid bit and fills bubbles; a stall holds all data in place
// rst_n clears valid bits and configuration registers, no clearing pass
module synapse_weight_index_resolver #(
    parameter int NEURON_INDEX_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pre_global_id, post_index
    input  logic        s_tuser,   // remap_allowed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // req_pre_index, req_post_index, weight_key
    output logic        m_tuser,   // valid_res
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import swir_pkg::*;

    localparam logic [16:0] IdxMaskWide =
        (NEURON_INDEX_BITS >= 16) ? 17'h0FFFF : ((17'd1 << NEURON_INDEX_BITS) - 17'd1);
    localparam logic [15:0] IdxMask = IdxMaskWide[15:0];

    logic [15:0] neuron_count_reg;
    logic        post_row_layout_reg;
    logic [15:0] column_count_reg;
    logic [31:0] window_base_reg;
    logic [15:0] core_number_reg;

    logic      stg_valid [DIV_STAGES+1];
    logic      stg_ready [DIV_STAGES+1];
    div_item_t stg_item  [DIV_STAGES+1];
    result_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neuron_count_reg    <= 16'd0;
            post_row_layout_reg <= 1'b0;
            column_count_reg    <= 16'd0;
            window_base_reg     <= 32'd0;
            core_number_reg     <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEURON_COUNT:    neuron_count_reg    <= cfg_data[15:0];
                REG_POST_ROW_LAYOUT: post_row_layout_reg <= cfg_data[0];
                REG_COLUMN_COUNT:    column_count_reg    <= cfg_data[15:0];
                REG_WINDOW_BASE:     window_base_reg     <= cfg_data;
                REG_CORE_NUMBER:     core_number_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    swir_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_pre          (s_tdata[31:0]),
        .in_post         (s_tdata[63:32]),
        .in_remap        (s_tuser),
        .neuron_count    (neuron_count_reg),
        .post_row_layout (post_row_layout_reg),
        .column_count    (column_count_reg),
        .window_base     (window_base_reg),
        .core_number     (core_number_reg),
        .out_valid       (stg_valid[0]),
        .out_ready       (stg_ready[0]),
        .out_item        (stg_item[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_rem
        swir_rem_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .divisor   (neuron_count_reg),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    swir_key #(
        .IDX_MASK (IdxMask)
    ) u_key (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (stg_valid[DIV_STAGES]),
        .in_ready        (stg_ready[DIV_STAGES]),
        .in_item         (stg_item[DIV_STAGES]),
        .neuron_count    (neuron_count_reg),
        .post_row_layout (post_row_layout_reg),
        .column_count    (column_count_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_res         (res)
    );

    assign m_tdata = {res.weight_key, res.req_post_index, res.req_pre_index};
    assign m_tuser = res.valid_res;

endmodule

>>> tb/tb_synapse_weight_index_resolver.sv
// self-checking testbench of the synapse weight index resolver with its own index predictor
module tb_synapse_weight_index_resolver;

    import swir_pkg::*;

    localparam int          HALF_PERIOD      = 10;
    localparam int          RESET_CYCLES     = 12;
    localparam int          MAX_GAP          = 14;
    localparam int          HOLD_CYCLES      = 600;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          RANDOM_SPIKES    = 750;
    localparam int          HOLD_AFTER       = 200;
    localparam int          HOLD_PHASE_LEN   = 80;
    localparam logic [2:0]  REG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  REG_LAST_UNUSED  = 3'd7;
    localparam result_t     REJECTED         = '0;

    typedef enum logic {ROW_CONFIG, ROW_SPIKE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic [31:0] pre;
        logic [31:0] post;
        logic        remap;
        logic        typed;
        result_t     result;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // register copies for the predictor
    logic [15:0] neuron_count;
    logic        post_row_layout;
    logic [15:0] column_count;
    logic [31:0] window_base;
    logic [15:0] core_number;

    result_t       pending_lookups[$];
    directed_row_t directed_rows[$];
    int            mismatch_count;
    bit            no_idle;
    bit            hold_off_req;
    bit            sink_holding;

    synapse_weight_index_resolver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic result_t resolve_weight_index(logic [31:0] pre, logic [31:0] post,
                                                     logic remap);
        logic [63:0] pre_w;
        logic [63:0] post_w;
        logic [63:0] count_w;
        logic [63:0] cols_w;
        logic [63:0] base_w;
        logic [63:0] origin;
        logic [63:0] diff;
        logic [63:0] pre_idx;
        logic [63:0] key;
        result_t     res;
        res     = REJECTED;
        pre_w   = {32'd0, pre};
        post_w  = {32'd0, post};
        count_w = {48'd0, neuron_count};
        cols_w  = {48'd0, column_count};
        base_w  = {32'd0, window_base};
        if (post_w >= count_w)
            return res;
        if (post_row_layout)
        begin
            if (cols_w == 0 || pre_w >= cols_w)
                return res;
            key = post_w * cols_w + pre_w;
            res.valid_res      = 1'b1;
            res.req_pre_index  = pre[15:0];
            res.req_post_index = post[15:0];
            res.weight_key     = key[31:0];
            return res;
        end
        if (pre_w >= base_w && pre_w < base_w + count_w)
            pre_idx = pre_w - base_w;
        else
        begin
            if (!remap || count_w == 0)
                return res;
            origin  = base_w - {48'd0, core_number} * count_w;
            diff    = pre_w - origin;
            pre_idx = diff % count_w;
        end
        key = pre_idx * count_w + post_w;
        res.valid_res      = 1'b1;
        res.req_pre_index  = pre_idx[15:0];
        res.req_post_index = post[15:0];
        res.weight_key     = key[31:0];
        return res;
    endfunction

    function automatic directed_row_t config_row(logic [2:0] index, logic [31:0] value);
        directed_row_t row;
        row           = '0;
        row.kind      = ROW_CONFIG;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic directed_row_t spike_row(logic [31:0] pre, logic [31:0] post,
                                                logic remap, logic typed, result_t result);
        directed_row_t row;
        row        = '0;
        row.kind   = ROW_SPIKE;
        row.pre    = pre;
        row.post   = post;
        row.remap  = remap;
        row.typed  = typed;
        row.result = result;
        return row;
    endfunction

    function automatic logic [15:0] pick_extreme16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(2, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    // single write per call, cfg_we is lowered by the caller
    task automatic set_register(logic [2:0] index, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_NEURON_COUNT:    neuron_count    = value[15:0];
            REG_POST_ROW_LAYOUT: post_row_layout = value[0];
            REG_COLUMN_COUNT:    column_count    = value[15:0];
            REG_WINDOW_BASE:     window_base     = value;
            REG_CORE_NUMBER:     core_number     = value[15:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_spike(logic [31:0] pre, logic [31:0] post, logic remap,
                              logic typed, result_t typed_result);
        int gap;
        gap = (no_idle || sink_holding) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {post, pre};
        s_tuser  <= remap;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        pending_lookups.push_back(typed ? typed_result : resolve_weight_index(pre, post, remap));
    endtask

    task automatic send_random_spike();
        logic [31:0] pre;
        logic [31:0] post;
        logic        remap;
        int          pick;
        pick = $urandom_range(0, 9);
        if (neuron_count != 0 && pick < 8)
            post = $urandom % neuron_count;
        else if (pick == 8)
            post = 32'(neuron_count) + $urandom_range(0, 3);
        else
            post = $urandom;
        pick = $urandom_range(0, 9);
        if (post_row_layout)
        begin
            if (column_count != 0 && pick < 7)
                pre = $urandom % column_count;
            else if (pick == 7)
                pre = 32'(column_count);
            else
                pre = $urandom;
        end
        else
        begin
            if (neuron_count != 0 && pick < 4)
                pre = window_base + ($urandom % neuron_count);
            else if (pick == 4)
                pre = window_base - 1;
            else if (pick == 5)
                pre = window_base + 32'(neuron_count);
            else
                pre = $urandom;
        end
        remap = ($urandom_range(0, 3) != 0);
        send_spike(pre, post, remap, 1'b0, REJECTED);
    endtask

    // output side: random stalls, stretches without stalls, one long hold-off
    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                sink_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_holding = 1'b0;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid_res      = m_tuser;
            got.req_pre_index  = m_tdata[15:0];
            got.req_post_index = m_tdata[31:16];
            got.weight_key     = m_tdata[63:32];
            if (pending_lookups.size() == 0)
            begin
                $error("unexpected transfer: tdata %h tuser %b", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (got.valid_res !== want.valid_res)
                begin
                    $error("valid_res: expected %b, got %b", want.valid_res, got.valid_res);
                    mismatch_count++;
                end
                if (got.req_pre_index !== want.req_pre_index)
                begin
                    $error("req_pre_index: expected %h, got %h",
                           want.req_pre_index, got.req_pre_index);
                    mismatch_count++;
                end
                if (got.req_post_index !== want.req_post_index)
                begin
                    $error("req_post_index: expected %h, got %h",
                           want.req_post_index, got.req_post_index);
                    mismatch_count++;
                end
                if (got.weight_key !== want.weight_key)
                begin
                    $error("weight_key: expected %h, got %h", want.weight_key, got.weight_key);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("[synapse_weight_index_resolver] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int            random_sent;
        int            phase_len;
        bit            hold_done;
        directed_row_t row;
        mismatch_count  = 0;
        no_idle         = 1'b0;
        hold_off_req    = 1'b0;
        sink_holding    = 1'b0;
        hold_done       = 1'b0;
        neuron_count    = '0;
        post_row_layout = 1'b0;
        column_count    = '0;
        window_base     = '0;
        core_number     = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // state after reset, then extremes of fields and registers
        directed_rows.push_back(spike_row(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, REJECTED));
        directed_rows.push_back(config_row(REG_NEURON_COUNT, 32'h0000_FFFF));
        directed_rows.push_back(config_row(REG_POST_ROW_LAYOUT, 32'h0));
        directed_rows.push_back(config_row(REG_COLUMN_COUNT, 32'hFFFF_FFFF));
        directed_rows.push_back(config_row(REG_WINDOW_BASE, 32'hFFFF_0000));
        directed_rows.push_back(config_row(REG_CORE_NUMBER, 32'h0000_FFFF));
        directed_rows.push_back(spike_row(32'hFFFF_0000, 32'h0, 1'b0, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'hFFFF_FFFE, 32'hFFFE, 1'b0, 1'b0, REJECTED));
        // foreign id without remap
        directed_rows.push_back(spike_row(32'hFFFF_FFFF, 32'h1, 1'b0, 1'b1, REJECTED));
        directed_rows.push_back(spike_row(32'hFFFF_FFFF, 32'h1, 1'b1, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'h0, 32'hFFFE, 1'b1, 1'b0, REJECTED));
        // post index out of range
        directed_rows.push_back(spike_row(32'h0, 32'hFFFF, 1'b1, 1'b1, REJECTED));
        directed_rows.push_back(spike_row(32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 1'b1, REJECTED));
        // post-row layout
        directed_rows.push_back(config_row(REG_POST_ROW_LAYOUT, 32'h1));
        directed_rows.push_back(config_row(REG_COLUMN_COUNT, 32'h1));
        directed_rows.push_back(spike_row(32'h0, 32'h5, 1'b0, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'h1, 32'h5, 1'b1, 1'b1, REJECTED));
        directed_rows.push_back(config_row(REG_COLUMN_COUNT, 32'hABCD_0000));
        directed_rows.push_back(spike_row(32'h0, 32'h0, 1'b1, 1'b1, REJECTED));
        directed_rows.push_back(config_row(REG_COLUMN_COUNT, 32'hFFFF));
        directed_rows.push_back(config_row(REG_NEURON_COUNT, 32'h1));
        directed_rows.push_back(spike_row(32'hFFFE, 32'h0, 1'b0, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'hFFFF, 32'h0, 1'b0, 1'b1, REJECTED));
        directed_rows.push_back(spike_row(32'h0, 32'h1, 1'b0, 1'b1, REJECTED));
        // single-neuron window, remap folds everything to zero
        directed_rows.push_back(config_row(REG_POST_ROW_LAYOUT, 32'hFFFF_FFFE));
        directed_rows.push_back(config_row(REG_WINDOW_BASE, 32'h0));
        directed_rows.push_back(config_row(REG_CORE_NUMBER, 32'h0));
        directed_rows.push_back(spike_row(32'h0, 32'h0, 1'b0, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, REJECTED));
        // zero neuron count
        directed_rows.push_back(config_row(REG_NEURON_COUNT, 32'hFFFF_0000));
        directed_rows.push_back(spike_row(32'h0, 32'h0, 1'b1, 1'b1, REJECTED));
        // write to an unused index has no effect
        directed_rows.push_back(config_row(REG_LAST_UNUSED, 32'hFFFF_FFFF));
        directed_rows.push_back(config_row(REG_NEURON_COUNT, 32'd7));
        directed_rows.push_back(config_row(REG_WINDOW_BASE, 32'd100));
        directed_rows.push_back(config_row(REG_CORE_NUMBER, 32'd3));
        directed_rows.push_back(spike_row(32'd106, 32'd6, 1'b0, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'd107, 32'd0, 1'b0, 1'b1, REJECTED));
        directed_rows.push_back(spike_row(32'd3, 32'd2, 1'b1, 1'b0, REJECTED));
        directed_rows.push_back(spike_row(32'd107, 32'd0, 1'b1, 1'b0, REJECTED));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                wait_drained();
                set_register(row.reg_index, row.reg_value);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_spike(row.pre, row.post, row.remap, row.typed, row.result);
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_SPIKES)
        begin
            wait_drained();
            set_register(REG_NEURON_COUNT, {16'($urandom), pick_extreme16()});
            set_register(REG_POST_ROW_LAYOUT, {31'($urandom), $urandom_range(0, 2) == 0});
            set_register(REG_COLUMN_COUNT, {16'($urandom), pick_extreme16()});
            case ($urandom_range(0, 4))
                0:       set_register(REG_WINDOW_BASE, 32'h0);
                1:       set_register(REG_WINDOW_BASE, 32'hFFFF_FFFF);
                2:       set_register(REG_WINDOW_BASE, 32'hFFFF_0000 | $urandom_range(0, 255));
                default: set_register(REG_WINDOW_BASE, $urandom);
            endcase
            set_register(REG_CORE_NUMBER, {16'($urandom), pick_extreme16()});
            if ($urandom_range(0, 3) == 0)
                set_register(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom);
            cfg_we  <= 1'b0;
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            // long phase so the pipeline fills while the sink holds off
            if (!hold_done && random_sent >= HOLD_AFTER)
            begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                phase_len    = HOLD_PHASE_LEN;
            end
            repeat (phase_len)
            begin
                send_random_spike();
                random_sent++;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("[synapse_weight_index_resolver] OK");
        else
            $display("[synapse_weight_index_resolver] ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/swir_pkg.sv
sv/swir_front.sv
sv/swir_rem_stage.sv
sv/swir_key.sv
sv/synapse_weight_index_resolver.sv
tb/tb_synapse_weight_index_resolver.sv
